>>> rtl/core/lspv_pkg.sv
`timescale 1ns / 1ps
package lspv_pkg;

  // item actions
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;
  localparam logic [1:0] ACT_TICK  = 2'd3;

  // configuration register map
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_FRAMES    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO_ON     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_ON    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ON       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_START    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_END      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CROSSFADE_LEN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO    = 3'd7;

  // shared divider
  localparam int DIV_REM_W = 17;
  localparam int DIV_DVD_W = 18;
  localparam int DIV_CNT_W = 5;

  typedef struct packed {
    logic [1:0]         action;
    logic [15:0]        frame_address;
    logic signed [15:0] left_value;
    logic signed [15:0] right_value;
    logic [15:0]        pitch_scale;
  } lspv_in_t;

  typedef struct packed {
    logic signed [15:0] audio_out;
    logic               playing;
    logic               done_res;
  } lspv_out_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_REM_W-1:0] rem_init;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_REM_W-1:0] divisor;
    logic [DIV_CNT_W-1:0] iters;
  } lspv_div_req_t;

  typedef struct packed {
    logic                 busy;
    logic [DIV_DVD_W-1:0] quotient;
    logic [DIV_REM_W-1:0] remainder;
  } lspv_div_rsp_t;

endpackage

>>> rtl/core/lspv_ram.sv
`timescale 1ns / 1ps
module lspv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/lspv_div.sv
`timescale 1ns / 1ps
module lspv_div (
  input  logic                   clk,
  input  logic                   rst,
  input  lspv_pkg::lspv_div_req_t req,
  output lspv_pkg::lspv_div_rsp_t rsp
);
  import lspv_pkg::*;

  logic [DIV_REM_W-1:0] rem;
  logic [DIV_DVD_W-1:0] sh;
  logic [DIV_REM_W-1:0] dv;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DIV_REM_W+1:0] diff;

  // trial subtract of the divisor from the partial remainder with the next bit
  assign diff = {1'b0, rem, sh[DIV_DVD_W-1]} - {2'b00, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      rem  <= req.rem_init;
      sh   <= req.dividend;
      dv   <= req.divisor;
      cnt  <= req.iters;
      busy <= (req.iters != '0);
    end else if (busy) begin
      if (diff[DIV_REM_W+1]) begin
        rem <= {rem[DIV_REM_W-2:0], sh[DIV_DVD_W-1]};
      end else begin
        rem <= diff[DIV_REM_W-1:0];
      end
      sh  <= {sh[DIV_DVD_W-2:0], ~diff[DIV_REM_W+1]};
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign rsp = '{busy: busy, quotient: sh, remainder: rem};

endmodule

>>> rtl/core/looping_sample_voice_player_unit.sv
`timescale 1ns / 1ps
// Load, start, stop and idle tick words go to S_DONE, which registers the result once
// the output is free. A playing tick is longer with stereo, crossfade and a wrap before
// and after the advance; the single multiplier and the bit-serial divider (18 steps
// per wrap, 17 per crossfade mix) set its length.
// One word is in work at a time; a finished result may wait while the next is taken.
// Reset: voice idle with done set, configuration at defaults, sample memory not cleared.
module looping_sample_voice_player_unit #(
  parameter int SAMPLE_DEPTH = 65536,
  parameter int SAMPLE_BITS  = 16,
  parameter int FADE_IN_LEN  = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  lspv_pkg::lspv_in_t                  item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output lspv_pkg::lspv_out_t                 result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lspv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lspv_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lspv_pkg::*;

  localparam int AW    = $clog2(SAMPLE_DEPTH);
  localparam int SW    = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
  localparam int PAD   = 16 - SW;
  localparam int NCAP  = (SAMPLE_DEPTH > 131071) ? 131071 : SAMPLE_DEPTH;
  localparam int FSTEP = (65536 + FADE_IN_LEN - 1) / FADE_IN_LEN;

  typedef enum logic [4:0] {
    S_IDLE, S_WRAP, S_WDIV, S_WFIX, S_CHECK, S_FETCH, S_HMUL, S_HADD,
    S_BLEND0, S_BLEND1, S_BLEND2, S_GAIN0, S_GAIN1, S_STEP0, S_STEP1,
    S_STORE, S_DONE
  } state_t;

  // configuration
  logic [16:0] num_frames;
  logic        stereo_on, reverse_on, loop_on;
  logic [15:0] loop_start;
  logic [16:0] loop_end;
  logic [15:0] crossfade_len;
  logic [23:0] step_ratio;

  // voice state and datapath registers
  state_t             state;
  logic               post, sel, xfade, ch;
  logic [1:0]         hs;
  logic [2:0]         cnt;
  logic signed [34:0] play_position, pos2;
  logic [15:0]        frac;
  logic signed [15:0] xl [4];
  logic signed [15:0] xr [4];
  logic signed [21:0] t, hl, va, vb, vfin;
  logic signed [42:0] acc, prod;
  logic signed [15:0] audio;
  logic [15:0]        pitch;
  logic [16:0]        fade_gain;
  logic               active_flag, finished_flag;

  // derived configuration
  logic [16:0]        n, hi, loop_len, span_fr, ef_fr, er_fr;
  logic [15:0]        half, xf;
  logic               loop_ok, rev;
  logic signed [34:0] ls65, le65, n65, ef65, er65, span65;

  always_comb begin
    n        = (num_frames > 17'(NCAP)) ? 17'(NCAP) : num_frames;
    hi       = (n == '0) ? '0 : n - 17'd1;
    rev      = reverse_on;
    loop_ok  = loop_on && (loop_end > 17'(loop_start)) && (loop_end <= n);
    loop_len = loop_end - 17'(loop_start);
    half     = 16'(loop_len >> 1);
    xf       = loop_ok ? ((crossfade_len < half) ? crossfade_len : half) : '0;
    span_fr  = loop_len - 17'(xf);
    ef_fr    = loop_end - 17'(xf);
    er_fr    = 17'(loop_start) + 17'(xf);
    ls65     = $signed({3'b000, loop_start, 16'h0000});
    le65     = $signed({2'b00, loop_end, 16'h0000});
    n65      = $signed({2'b00, n, 16'h0000});
    ef65     = $signed({2'b00, ef_fr, 16'h0000});
    er65     = $signed({2'b00, er_fr, 16'h0000});
    span65   = $signed({2'b00, span_fr, 16'h0000});
  end

  // sample memories
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [SW-1:0] rd_l, rd_r;
  logic signed [15:0] xin_l, xin_r;

  assign ram_we = item_valid && item_ready && (item.action == ACT_LOAD) &&
                  (32'(item.frame_address) < 32'(SAMPLE_DEPTH));

  lspv_ram #(.WIDTH(SW), .DEPTH(SAMPLE_DEPTH)) u_ram_left (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(item.frame_address)),
    .wdata (SW'(16'(item.left_value) >> PAD)),
    .raddr (ram_raddr),
    .rdata (rd_l)
  );

  lspv_ram #(.WIDTH(SW), .DEPTH(SAMPLE_DEPTH)) u_ram_right (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(item.frame_address)),
    .wdata (SW'(16'(item.right_value) >> PAD)),
    .raddr (ram_raddr),
    .rdata (rd_r)
  );

  assign xin_l = $signed(16'(rd_l) << PAD);
  assign xin_r = $signed(16'(rd_r) << PAD);

  // interpolation point and clamped tap address
  logic signed [34:0] ipos;
  logic signed [19:0] kk;
  logic [16:0]        kc;

  always_comb begin
    ipos = sel ? pos2 : play_position;
    kk   = $signed({ipos[34], ipos[34:16]}) - 20'sd1 + $signed(20'(cnt));
    if (kk[19]) begin
      kc = '0;
    end else if ((kk[18:17] != 2'b00) || (kk[16:0] > hi)) begin
      kc = hi;
    end else begin
      kc = kk[16:0];
    end
    ram_raddr = AW'(kc);
  end

  // Hermite coefficients of the channel in work
  logic signed [21:0] sx0, sx1, sx2, sx3, k0, k1, k2, k3, ksel;

  always_comb begin
    sx0  = ch ? 22'(xr[0]) : 22'(xl[0]);
    sx1  = ch ? 22'(xr[1]) : 22'(xl[1]);
    sx2  = ch ? 22'(xr[2]) : 22'(xl[2]);
    sx3  = ch ? 22'(xr[3]) : 22'(xl[3]);
    k0   = sx1 <<< 1;
    k1   = sx2 - sx0;
    k2   = (sx0 <<< 1) - (sx1 <<< 2) - sx1 + (sx2 <<< 2) - sx3;
    k3   = (sx3 - sx0) + ((sx1 - sx2) <<< 1) + (sx1 - sx2);
    case (hs)
      2'd0:    ksel = k2;
      2'd1:    ksel = k1;
      default: ksel = k0;
    endcase
  end

  // shared divider
  lspv_div_req_t div_req;
  lspv_div_rsp_t div_rsp;

  lspv_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  logic signed [34:0] a_w, b_w, d_w;
  logic               fwd_need, rev_need, out_now, go_xf;
  logic [16:0]        mixc;

  always_comb begin
    a_w      = play_position - le65;
    b_w      = ls65 - play_position;
    fwd_need = !rev && (play_position >= le65);
    rev_need = rev && (play_position < ls65);
    out_now  = rev ? play_position[34] : (play_position >= n65);
    go_xf    = loop_ok && (xf != '0) &&
               (rev ? (play_position <= er65) : (play_position >= ef65));
    d_w      = rev ? (er65 - play_position) : (play_position - ef65);
    mixc     = (div_rsp.quotient > 18'd65536) ? 17'd65536 : div_rsp.quotient[16:0];

    div_req = '0;
    if ((state == S_WRAP) && loop_ok && (fwd_need || rev_need)) begin
      div_req.start    = 1'b1;
      div_req.dividend = rev ? b_w[33:16] : a_w[33:16];
      div_req.divisor  = span_fr;
      div_req.iters    = DIV_CNT_W'(DIV_DVD_W);
    end else if ((state == S_CHECK) && !(!loop_ok && out_now) && go_xf) begin
      // the high part of the offset is always below the crossfade length
      div_req.start    = 1'b1;
      div_req.rem_init = 17'(d_w[31:17]);
      div_req.dividend = {d_w[16:0], 1'b0};
      div_req.divisor  = 17'(xf);
      div_req.iters    = DIV_CNT_W'(DIV_DVD_W - 1);
    end
  end

  // shared multiplier operands
  logic signed [24:0] mul_a;
  logic signed [17:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_HMUL: begin
        mul_a = (hs == 2'd0) ? 25'(k3) : 25'(t);
        mul_b = $signed({2'b00, ipos[15:0]});
      end
      S_BLEND0: begin
        mul_a = 25'(va);
        mul_b = $signed({1'b0, 17'd65536 - mixc});
      end
      S_BLEND1: begin
        mul_a = 25'(vb);
        mul_b = $signed({1'b0, mixc});
      end
      S_GAIN0: begin
        mul_a = 25'(vfin);
        mul_b = $signed({1'b0, fade_gain});
      end
      S_STEP0: begin
        mul_a = $signed({1'b0, step_ratio});
        mul_b = $signed({2'b00, pitch});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // rounding and per-step results
  logic signed [42:0] r16, g18, inc_s;
  logic signed [43:0] bsum;
  logic signed [21:0] hnew, ival;
  logic [26:0]        inc;
  logic signed [34:0] pos_n;
  logic [17:0]        fsum;

  always_comb begin
    r16   = prod + 43'sd32768;
    hnew  = $signed(r16[37:16]) + ksel;
    ival  = ch ? (hl + hnew) : (hnew <<< 1);
    bsum  = 44'(acc) + 44'(prod) + 44'sd32768;
    g18   = (prod + 43'sd131072) >>> 18;
    inc_s = prod + 43'sd8192;
    inc   = inc_s[40:14];
    pos_n = rev ? (play_position - 35'(inc)) : (play_position + 35'(inc));
    fsum  = 18'(fade_gain) + 18'(FSTEP);
  end

  assign item_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_frames    <= '0;
      stereo_on     <= 1'b0;
      reverse_on    <= 1'b0;
      loop_on       <= 1'b0;
      loop_start    <= '0;
      loop_end      <= '0;
      crossfade_len <= '0;
      step_ratio    <= 24'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NUM_FRAMES:    num_frames    <= cfg_data[16:0];
        REG_STEREO_ON:     stereo_on     <= cfg_data[0];
        REG_REVERSE_ON:    reverse_on    <= cfg_data[0];
        REG_LOOP_ON:       loop_on       <= cfg_data[0];
        REG_LOOP_START:    loop_start    <= cfg_data[15:0];
        REG_LOOP_END:      loop_end      <= cfg_data[16:0];
        REG_CROSSFADE_LEN: crossfade_len <= cfg_data[15:0];
        REG_STEP_RATIO:    step_ratio    <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state         <= S_IDLE;
      result_valid  <= 1'b0;
      active_flag   <= 1'b0;
      finished_flag <= 1'b1;
      play_position <= '0;
      fade_gain     <= '0;
      post          <= 1'b0;
      sel           <= 1'b0;
      xfade         <= 1'b0;
      ch            <= 1'b0;
      hs            <= '0;
      cnt           <= '0;
    end else begin
      if (result_valid && result_ready && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            audio <= '0;
            state <= S_DONE;
            unique case (item.action)
              ACT_LOAD: begin
              end
              ACT_START: begin
                if (n == '0) begin
                  active_flag   <= 1'b0;
                  finished_flag <= 1'b1;
                end else begin
                  play_position <= rev ? $signed({2'b00, hi, 16'h0000}) : '0;
                  fade_gain     <= '0;
                  active_flag   <= 1'b1;
                  finished_flag <= 1'b0;
                end
              end
              ACT_STOP: begin
                active_flag   <= 1'b0;
                finished_flag <= 1'b1;
              end
              ACT_TICK: begin
                if (active_flag) begin
                  pitch <= item.pitch_scale;
                  post  <= 1'b0;
                  state <= S_WRAP;
                end
              end
            endcase
          end
        end
        S_WRAP: begin
          frac <= rev ? b_w[15:0] : a_w[15:0];
          if (loop_ok && (fwd_need || rev_need)) begin
            state <= S_WDIV;
          end else begin
            state <= post ? S_STORE : S_CHECK;
          end
        end
        S_WDIV: begin
          if (!div_rsp.busy) begin
            state <= S_WFIX;
          end
        end
        S_WFIX: begin
          // fold the offset back into the loop body past the crossfade
          if (rev) begin
            play_position <= ef65 - $signed(35'({div_rsp.remainder, frac}));
          end else begin
            play_position <= er65 + $signed(35'({div_rsp.remainder, frac}));
          end
          state <= post ? S_STORE : S_CHECK;
        end
        S_CHECK: begin
          if (!loop_ok && out_now) begin
            active_flag   <= 1'b0;
            finished_flag <= 1'b1;
            audio         <= '0;
            state         <= S_STORE;
          end else begin
            xfade <= go_xf;
            pos2  <= rev ? (play_position + span65) : (play_position - span65);
            sel   <= 1'b0;
            ch    <= 1'b0;
            hs    <= '0;
            cnt   <= '0;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (cnt != '0) begin
            xl[2'(cnt - 3'd1)] <= xin_l;
            xr[2'(cnt - 3'd1)] <= xin_r;
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'd4) begin
            state <= S_HMUL;
          end
        end
        S_HMUL: begin
          state <= S_HADD;
        end
        S_HADD: begin
          t <= hnew;
          if (hs != 2'd2) begin
            hs    <= hs + 2'd1;
            state <= S_HMUL;
          end else if (!ch && stereo_on) begin
            hl    <= hnew;
            ch    <= 1'b1;
            hs    <= '0;
            state <= S_HMUL;
          end else if (!sel) begin
            va <= ival;
            if (xfade) begin
              sel   <= 1'b1;
              ch    <= 1'b0;
              hs    <= '0;
              cnt   <= '0;
              state <= S_FETCH;
            end else begin
              vfin  <= ival;
              state <= S_GAIN0;
            end
          end else begin
            vb    <= ival;
            state <= S_BLEND0;
          end
        end
        S_BLEND0: begin
          // hold until the mix quotient is ready
          if (!div_rsp.busy) begin
            state <= S_BLEND1;
          end
        end
        S_BLEND1: begin
          acc   <= prod;
          state <= S_BLEND2;
        end
        S_BLEND2: begin
          vfin  <= bsum[37:16];
          state <= S_GAIN0;
        end
        S_GAIN0: begin
          state <= S_GAIN1;
        end
        S_GAIN1: begin
          if (g18 > 43'sd32767) begin
            audio <= 16'sh7FFF;
          end else if (g18 < -43'sd32768) begin
            audio <= 16'sh8000;
          end else begin
            audio <= g18[15:0];
          end
          if (fade_gain < 17'd65536) begin
            fade_gain <= (fsum > 18'd65536) ? 17'd65536 : fsum[16:0];
          end
          state <= S_STEP0;
        end
        S_STEP0: begin
          state <= S_STEP1;
        end
        S_STEP1: begin
          play_position <= pos_n;
          if (loop_ok) begin
            post  <= 1'b1;
            state <= S_WRAP;
          end else begin
            if (rev ? pos_n[34] : (pos_n >= n65)) begin
              active_flag   <= 1'b0;
              finished_flag <= 1'b1;
            end
            state <= S_STORE;
          end
        end
        S_STORE: begin
          // saturate to the 33-bit position range
          if ((play_position[34:32] != 3'b000) && (play_position[34:32] != 3'b111)) begin
            play_position <= play_position[34] ? 35'sh7_0000_0000 : 35'sh0_FFFF_FFFF;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result       <= '{audio_out: audio, playing: active_flag,
                              done_res: finished_flag};
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
      endcase
    end
  end

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    active_flag |-> !finished_flag)
    else $error("voice both active and finished");

  a_fade_max: assert property (@(posedge clk) disable iff (rst)
    fade_gain <= 17'd65536)
    else $error("fade gain above unity");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("second word taken while one is in work");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && (!result_valid || result_ready)) |=> result_valid)
    else $error("finished word not presented");

endmodule
